// File: rtl/iuc_pkg.sv
// Package for the interval union coverage block.
// Sizes, constants and the controller state type; no dependencies.
`timescale 1ns / 1ps
package iuc_pkg;
  localparam int MAX_INTERVALS = 256;
  localparam int COORD_BITS    = 20;
  localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);
  localparam int IDX_W         = $clog2(MAX_INTERVALS);
  localparam int POS_W         = COORD_BITS + 1;
  localparam int SCALE_W       = 11;
  localparam int NUM_W         = POS_W + SCALE_W;
  localparam int DEN_W         = COORD_BITS + 1;
  localparam int REM_W         = DEN_W + 1;
  localparam int DIV_CNT_W     = $clog2(NUM_W + 1);
  localparam int COV_W         = 16;

  localparam logic [SCALE_W-1:0] SCALE_TENTHS = SCALE_W'(2000);
  localparam logic [COV_W-1:0]   COVERAGE_TOP = '1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [POS_W-1:0]      pos_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_FIND,
    S_EXT,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;
endpackage

// File: rtl/iuc_if.sv
// Valid/ready channel interfaces for the input items and the results.
// Depends on iuc_pkg for the field widths.
`timescale 1ns / 1ps
interface iuc_in_if;
  logic                           valid;
  logic                           ready;
  logic [iuc_pkg::COORD_BITS-1:0] interval_start;
  logic [iuc_pkg::COORD_BITS-1:0] interval_end;
  logic [iuc_pkg::COORD_BITS-1:0] query_length;
  logic [iuc_pkg::COORD_BITS-1:0] subject_length;
  logic                           last_interval;
  modport source (output valid, interval_start, interval_end, query_length,
                  subject_length, last_interval, input ready);
  modport sink   (input valid, interval_start, interval_end, query_length,
                  subject_length, last_interval, output ready);
endinterface

interface iuc_out_if;
  logic                      valid;
  logic                      ready;
  logic [iuc_pkg::COV_W-1:0] coverage_tenths;
  logic                      zero_length;
  logic                      store_overflow;
  modport source (output valid, coverage_tenths, zero_length, store_overflow,
                  input ready);
  modport sink   (input valid, coverage_tenths, zero_length, store_overflow,
                  output ready);
endinterface

// File: rtl/interval_union_coverage_top.sv
// After the closing item of a group of n stored intervals, 2k+1 passes run, k being the
// number of extension passes (at most n); every pass scans the interval memory at one
// read a cycle, then a scaling step and 32 restoring divide steps follow. Throughput:
// items load one a cycle; input is held off from the closing item until the result
// register is loaded. Reset (rst_n, synchronous) clears the count, overflow flag, state
// and output valid; the interval memory is not cleared (only this group is read).
`timescale 1ns / 1ps
module interval_union_coverage_top (
  input logic      clk,
  input logic      rst_n,
  iuc_in_if.sink   in_ch,
  iuc_out_if.source out_ch
);
  import iuc_pkg::*;

  logic [2*COORD_BITS-1:0] mem [MAX_INTERVALS];
  logic [2*COORD_BITS-1:0] rd_data_r;
  logic [IDX_W-1:0]        rd_addr;
  logic                    rd_vld_r, rd_vld_nxt;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, idx_r, idx_nxt;
  logic             ovf_r, ovf_nxt;
  coord_t           len_r, len_nxt;
  pos_t             f_r, f_nxt, a_r, a_nxt, b_r, b_nxt, tot_r, tot_nxt;
  logic             found_r, found_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] dcnt_r, dcnt_nxt;
  logic             zero_r, zero_nxt;
  logic             ov_r, ov_nxt, oz_r, oz_nxt, oo_r, oo_nxt;
  logic [COV_W-1:0] oc_r, oc_nxt;

  coord_t s_in, e_in, lo_in, hi_in, lo_rd, hi_rd;
  pos_t   eff;
  logic   accept, wr_en, issue, pass_end;
  logic [REM_W-1:0] rem_sh;
  logic [DEN_W-1:0] den;

  assign s_in   = in_ch.interval_start;
  assign e_in   = in_ch.interval_end;
  assign lo_in  = (e_in < s_in) ? e_in : s_in;
  assign hi_in  = (e_in < s_in) ? s_in : e_in;
  assign accept = in_ch.valid && in_ch.ready;
  assign wr_en  = accept && (cnt_r < CNT_W'(MAX_INTERVALS));
  assign in_ch.ready = (state_r == S_LOAD);

  assign lo_rd  = rd_data_r[COORD_BITS-1:0];
  assign hi_rd  = rd_data_r[2*COORD_BITS-1:COORD_BITS];
  assign eff    = ({1'b0, lo_rd} > f_r) ? {1'b0, lo_rd} : f_r;
  assign issue  = (state_r == S_FIND || state_r == S_EXT) && (idx_r < cnt_r);
  assign rd_addr = idx_r[IDX_W-1:0];
  assign pass_end = (idx_r == cnt_r) && !rd_vld_r;
  assign den    = {len_r, 1'b0};
  assign rem_sh = {rem_r[REM_W-2:0], num_r[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_r[IDX_W-1:0]] <= {hi_in, lo_in};
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; idx_nxt = idx_r; ovf_nxt = ovf_r;
    len_nxt = len_r; f_nxt = f_r; a_nxt = a_r; b_nxt = b_r; tot_nxt = tot_r;
    found_nxt = found_r; num_nxt = num_r; rem_nxt = rem_r; dcnt_nxt = dcnt_r;
    zero_nxt = zero_r; ov_nxt = ov_r; oz_nxt = oz_r; oo_nxt = oo_r; oc_nxt = oc_r;
    rd_vld_nxt = issue;
    if (issue) idx_nxt = idx_r + 1'b1;
    if (ov_r && out_ch.ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        if (accept) begin
          if (wr_en) cnt_nxt = cnt_r + 1'b1;
          else       ovf_nxt = 1'b1;
          if (in_ch.last_interval) begin
            len_nxt = (in_ch.query_length < in_ch.subject_length) ?
                      in_ch.query_length : in_ch.subject_length;
            f_nxt = '0; tot_nxt = '0; found_nxt = 1'b0; idx_nxt = '0;
            state_nxt = S_FIND;
          end
        end
      end
      S_FIND: begin
        // smallest uncounted covered position at or above the frontier
        if (rd_vld_r && ({1'b0, hi_rd} >= f_r) && (!found_r || eff < a_r)) begin
          a_nxt = eff; found_nxt = 1'b1;
        end
        if (pass_end) begin
          idx_nxt = '0;
          if (found_r) begin
            b_nxt = a_r; state_nxt = S_EXT;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_EXT: begin
        if (rd_vld_r && ({1'b0, lo_rd} <= a_r) && ({1'b0, hi_rd} > b_r)) begin
          b_nxt = {1'b0, hi_rd};
        end
        if (pass_end) begin
          tot_nxt = tot_r + (b_r - a_r) + 1'b1;
          f_nxt = b_r + 1'b1;
          found_nxt = 1'b0; idx_nxt = '0;
          state_nxt = S_FIND;
        end
      end
      S_MUL: begin
        num_nxt = NUM_W'(tot_r) * NUM_W'(SCALE_TENTHS) + NUM_W'(len_r);
        zero_nxt = (len_r == '0);
        rem_nxt = '0; dcnt_nxt = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // restoring division, quotient shifts into num_r
        if (rem_sh >= REM_W'(den)) begin
          rem_nxt = rem_sh - REM_W'(den);
          num_nxt = {num_r[NUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          num_nxt = {num_r[NUM_W-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == DIV_CNT_W'(NUM_W - 1)) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt = 1'b1;
          oz_nxt = zero_r;
          oo_nxt = ovf_r;
          if (zero_r) oc_nxt = '0;
          else if (num_r > NUM_W'(COVERAGE_TOP)) oc_nxt = COVERAGE_TOP;
          else oc_nxt = num_r[COV_W-1:0];
          cnt_nxt = '0; ovf_nxt = 1'b0;
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; cnt_r <= '0; idx_r <= '0; ovf_r <= 1'b0;
      rd_vld_r <= 1'b0; ov_r <= 1'b0; found_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; idx_r <= idx_nxt; ovf_r <= ovf_nxt;
      rd_vld_r <= rd_vld_nxt; ov_r <= ov_nxt; found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt; f_r <= f_nxt; a_r <= a_nxt; b_r <= b_nxt; tot_r <= tot_nxt;
    num_r <= num_nxt; rem_r <= rem_nxt; dcnt_r <= dcnt_nxt; zero_r <= zero_nxt;
    oz_r <= oz_nxt; oo_r <= oo_nxt; oc_r <= oc_nxt;
  end

  assign out_ch.valid           = ov_r;
  assign out_ch.coverage_tenths = oc_r;
  assign out_ch.zero_length     = oz_r;
  assign out_ch.store_overflow  = oo_r;
endmodule
